// ===== hw/rtl/nlt_pkg.sv =====
`default_nettype none

package nlt_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int FUNC_W       = 3;
    localparam int ID_W         = 8;
    localparam int SOIL_W       = 8;
    localparam int TIME_W       = 32;
    localparam int REQ_BAND_W   = 8;
    localparam int BAND_W       = 7;
    localparam int STATUS_W     = 2;
    localparam int MASK_W       = 16;
    localparam int NODE_TOTAL_W = 5;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 32;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_SEEN     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHECK    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SWEEP    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_OFFLINE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SET_BAND = 3'd4;

    // result codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_BAND  = 2'd3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEF_LOW   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEF_HIGH  = 2'd2;

    localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd30000;
    localparam logic [BAND_W-1:0] DEF_LOW_RST  = 7'd30;
    localparam logic [BAND_W-1:0] DEF_HIGH_RST = 7'd70;
    localparam logic [REQ_BAND_W-1:0] BAND_LIMIT = 8'd100;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [ID_W-1:0]       node_id;
        logic [SOIL_W-1:0]     soil;
        logic [TIME_W-1:0]     now_ms;
        logic [REQ_BAND_W-1:0] band_low;
        logic [REQ_BAND_W-1:0] band_high;
    } nlt_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic                    exceeded;
        logic                    became_online;
        logic [MASK_W-1:0]       timeout_mask;
        logic [NODE_TOTAL_W-1:0] node_total;
    } nlt_out_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic eval;
        logic commit;
        logic create_en;
        logic band_ok;
    } nlt_ctrl_t;

    // rippled from cell to cell, lowest slot first
    typedef struct packed {
        logic hit;
        logic free_seen;
        logic exceeded;
        logic became;
    } nlt_link_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EVAL,
        FSM_COMMIT
    } nlt_fsm_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nlt_cell.sv =====
`default_nettype none

module nlt_cell (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire nlt_pkg::nlt_in_t             cmd,
    input  wire nlt_pkg::nlt_ctrl_t           ctrl,
    input  wire logic [nlt_pkg::TIME_W-1:0]   timeout_ms,
    input  wire logic [nlt_pkg::BAND_W-1:0]   def_low,
    input  wire logic [nlt_pkg::BAND_W-1:0]   def_high,
    input  wire logic [nlt_pkg::BAND_W-1:0]   set_low,
    input  wire logic [nlt_pkg::BAND_W-1:0]   set_high,
    input  wire nlt_pkg::nlt_link_t           link_in,
    output nlt_pkg::nlt_link_t                link_out,
    output logic                              aged
);

    logic                          used_reg, used_next;
    logic                          online_reg, online_next;
    logic [nlt_pkg::ID_W-1:0]      id_reg, id_next;
    logic [nlt_pkg::TIME_W-1:0]    time_reg, time_next;
    logic [nlt_pkg::BAND_W-1:0]    low_reg, low_next;
    logic [nlt_pkg::BAND_W-1:0]    high_reg, high_next;
    logic                          exc_reg, exc_next;
    logic                          match_reg, match_next;
    logic                          aged_reg, aged_next;

    logic [nlt_pkg::TIME_W-1:0]    age;
    logic                          sel;
    logic                          create_here;
    logic                          outside;

    // eval phase: compare and age test, registered for the commit phase
    assign age = cmd.now_ms - time_reg;

    always_comb begin
        match_next = match_reg;
        aged_next  = aged_reg;
        if (ctrl.eval) begin
            match_next = used_reg && (id_reg == cmd.node_id);
            aged_next  = used_reg && online_reg && (age >= timeout_ms);
        end
    end

    // lowest matching slot wins; first free slot takes a new node
    assign sel         = match_reg && !link_in.hit;
    assign create_here = ctrl.create_en && !used_reg && !link_in.free_seen;
    assign outside     = (cmd.soil < {1'b0, low_reg}) || (cmd.soil > {1'b0, high_reg});

    assign link_out.hit       = link_in.hit | match_reg;
    assign link_out.free_seen = link_in.free_seen | !used_reg;
    assign link_out.exceeded  = link_in.exceeded | (sel & outside);
    assign link_out.became    = link_in.became | (sel & !online_reg);
    assign aged               = aged_reg;

    always_comb begin
        used_next   = used_reg;
        online_next = online_reg;
        id_next     = id_reg;
        time_next   = time_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        exc_next    = exc_reg;
        if (ctrl.commit) begin
            if (create_here) begin
                used_next   = 1'b1;
                online_next = 1'b0;
                id_next     = cmd.node_id;
                time_next   = '0;
                low_next    = def_low;
                high_next   = def_high;
                exc_next    = 1'b0;
            end
            case (cmd.func)
                nlt_pkg::FUNC_SEEN: begin
                    if (sel || create_here) begin
                        time_next   = cmd.now_ms;
                        online_next = 1'b1;
                    end
                end
                nlt_pkg::FUNC_CHECK: begin
                    if (sel) begin
                        exc_next = outside;
                    end
                end
                nlt_pkg::FUNC_SWEEP: begin
                    if (aged_reg) begin
                        online_next = 1'b0;
                    end
                end
                nlt_pkg::FUNC_OFFLINE: begin
                    if (sel) begin
                        online_next = 1'b0;
                    end
                end
                nlt_pkg::FUNC_SET_BAND: begin
                    if ((sel || create_here) && ctrl.band_ok) begin
                        low_next  = set_low;
                        high_next = set_high;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= 1'b0;
            online_reg <= 1'b0;
            match_reg  <= 1'b0;
            aged_reg   <= 1'b0;
        end else begin
            used_reg   <= used_next;
            online_reg <= online_next;
            match_reg  <= match_next;
            aged_reg   <= aged_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        time_reg <= time_next;
        low_reg  <= low_next;
        high_reg <= high_next;
        exc_reg  <= exc_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/node_liveness_table.sv =====
// Node liveness table: associative table of node ids with online ageing.
// s_ channel: one command transaction (seen, check band, sweep, mark
// offline, set band). m_ channel: exactly one result transaction per
// command, in command order. cfg_ port: register writes (timeout, default
// band low/high); the user must write only while the block is idle, as the
// block itself does not enforce it. A command taken in IDLE or COMMIT then
// passes EVAL, where every cell compares its id and age in parallel, and
// COMMIT, for the priority ripple along the cell chain and the write-back.
// The next command may be taken in the commit cycle of the one before.
// The result sits in an output register; the next command is taken and
// evaluated while it waits, and only its commit waits for m_ready, so a
// stalled receiver holds at most one result plus one command in flight.
// Reset (aresetn low, synchronous) empties the table, clears all online
// marks and loads the register defaults (30000 ms, band 30..70).

`default_nettype none

module node_liveness_table #(
    parameter int MAX_ENTRIES = nlt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // command channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire nlt_pkg::nlt_in_t                  s_data,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output nlt_pkg::nlt_out_t                      m_data,
    // register writes
    input  wire logic                              cfg_wr_en,
    input  wire logic [nlt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [nlt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    nlt_pkg::nlt_fsm_t   state_reg, state_next;
    nlt_pkg::nlt_in_t    cmd_reg;
    nlt_pkg::nlt_out_t   res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic [nlt_pkg::TIME_W-1:0] timeout_reg;
    logic [nlt_pkg::BAND_W-1:0] def_low_reg;
    logic [nlt_pkg::BAND_W-1:0] def_high_reg;

    logic                accept;
    logic                can_commit;
    logic                eval;
    logic                commit;
    nlt_pkg::nlt_ctrl_t  ctrl;
    nlt_pkg::nlt_link_t  link [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] aged_vec;

    logic                is_seen, is_check, is_sweep, is_offline, is_set;
    logic                any_hit, has_free, creates;
    logic [nlt_pkg::BAND_W-1:0] set_low, set_high;
    logic                band_ok;

    // ---------------------------------------------------------------
    // Register file
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= nlt_pkg::TIMEOUT_RST;
            def_low_reg  <= nlt_pkg::DEF_LOW_RST;
            def_high_reg <= nlt_pkg::DEF_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                nlt_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_wdata;
                nlt_pkg::CFG_DEF_LOW:  def_low_reg  <= cfg_wdata[nlt_pkg::BAND_W-1:0];
                nlt_pkg::CFG_DEF_HIGH: def_high_reg <= cfg_wdata[nlt_pkg::BAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: IDLE -> EVAL (cells compare) -> COMMIT (write-back).
    // A new command may be taken in the commit cycle, going straight to
    // EVAL.
    // ---------------------------------------------------------------
    assign can_commit = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nlt_pkg::FSM_IDLE: begin
                if (s_valid) state_next = nlt_pkg::FSM_EVAL;
            end
            nlt_pkg::FSM_EVAL: begin
                state_next = nlt_pkg::FSM_COMMIT;
            end
            nlt_pkg::FSM_COMMIT: begin
                if (can_commit) begin
                    state_next = s_valid ? nlt_pkg::FSM_EVAL : nlt_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = nlt_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        eval    = 1'b0;
        commit  = 1'b0;
        case (state_reg)
            nlt_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
            end
            nlt_pkg::FSM_EVAL: begin
                eval = 1'b1;
            end
            nlt_pkg::FSM_COMMIT: begin
                commit  = can_commit;
                s_ready = can_commit;
            end
            default: begin
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nlt_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // command holding register, stable through eval and commit
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_data;
        end
    end

    // ---------------------------------------------------------------
    // Command decode and band clamp
    // ---------------------------------------------------------------
    assign is_seen    = (cmd_reg.func == nlt_pkg::FUNC_SEEN);
    assign is_check   = (cmd_reg.func == nlt_pkg::FUNC_CHECK);
    assign is_sweep   = (cmd_reg.func == nlt_pkg::FUNC_SWEEP);
    assign is_offline = (cmd_reg.func == nlt_pkg::FUNC_OFFLINE);
    assign is_set     = (cmd_reg.func == nlt_pkg::FUNC_SET_BAND);

    assign set_low  = (cmd_reg.band_low > nlt_pkg::BAND_LIMIT)
                    ? nlt_pkg::BAND_LIMIT[nlt_pkg::BAND_W-1:0]
                    : cmd_reg.band_low[nlt_pkg::BAND_W-1:0];
    assign set_high = (cmd_reg.band_high > nlt_pkg::BAND_LIMIT)
                    ? nlt_pkg::BAND_LIMIT[nlt_pkg::BAND_W-1:0]
                    : cmd_reg.band_high[nlt_pkg::BAND_W-1:0];
    assign band_ok  = (set_low < set_high);

    // ---------------------------------------------------------------
    // Cell chain: slot 0 at the head, priority ripples towards the tail
    // ---------------------------------------------------------------
    assign link[0] = '0;

    assign any_hit  = link[MAX_ENTRIES].hit;
    assign has_free = link[MAX_ENTRIES].free_seen;

    assign ctrl.eval      = eval;
    assign ctrl.commit    = commit;
    assign ctrl.create_en = commit && (is_seen || is_set) && !any_hit;
    assign ctrl.band_ok   = band_ok;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        nlt_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd_reg),
            .ctrl       (ctrl),
            .timeout_ms (timeout_reg),
            .def_low    (def_low_reg),
            .def_high   (def_high_reg),
            .set_low    (set_low),
            .set_high   (set_high),
            .link_in    (link[i]),
            .link_out   (link[i+1]),
            .aged       (aged_vec[i])
        );
    end

    // ---------------------------------------------------------------
    // Result assembly and entry count
    // ---------------------------------------------------------------
    assign creates    = (is_seen || is_set) && !any_hit && has_free;
    assign count_next = (commit && creates) ? count_reg + CNT_W'(1) : count_reg;

    always_comb begin
        res_next               = '0;
        res_next.status        = nlt_pkg::ST_OK;
        res_next.node_total    = nlt_pkg::NODE_TOTAL_W'(count_next);
        if (is_seen) begin
            if (!any_hit && !has_free) begin
                res_next.status = nlt_pkg::ST_FULL;
            end else begin
                // a newly created node was offline by definition
                res_next.became_online = any_hit ? link[MAX_ENTRIES].became : 1'b1;
            end
        end else if (is_set) begin
            if (!any_hit && !has_free) begin
                res_next.status = nlt_pkg::ST_FULL;
            end else if (!band_ok) begin
                res_next.status = nlt_pkg::ST_BAD_BAND;
            end
        end else if (is_check) begin
            if (!any_hit) begin
                res_next.status = nlt_pkg::ST_NOT_FOUND;
            end else begin
                res_next.exceeded = link[MAX_ENTRIES].exceeded;
            end
        end else if (is_offline) begin
            if (!any_hit) begin
                res_next.status = nlt_pkg::ST_NOT_FOUND;
            end
        end else if (is_sweep) begin
            res_next.timeout_mask = nlt_pkg::MASK_W'(aged_vec);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

endmodule

`default_nettype wire

// ===== verif/node_liveness_table_tb.sv =====
`default_nettype none

// Self-checking bench for the node liveness table.
// A directed table of commands runs first, straight after reset, then eight
// random phases, each behind its own register setting. Every command
// transaction accepted on s_ is run through a behavioural copy of the table
// kept here, and the result it should give is queued. Every result
// transaction on m_ is compared field by field with the head of that queue.
module node_liveness_table_tb;

    import nlt_pkg::*;

    // Bench constants
    localparam int RESET_CYCLES    = 11;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int HOLD_CYCLES     = 300;     // long back-pressure stretch on m_
    localparam int DRAIN_CYCLES    = 4;       // margin kept after the result queue empties
    localparam int CYCLE_LIMIT     = 500_000;

    // Command codes with no defined behaviour: the block must answer ok
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    // Register index with nothing behind it: writes must be dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    localparam logic      TYPED   = 1'b1;    // directed row carries its answer
    localparam logic      PREDICT = 1'b0;    // directed row left to the predictor
    localparam nlt_out_t  NO_RES  = '0;

    typedef struct packed {
        nlt_in_t  cmd;
        logic     typed;
        nlt_out_t res;
    } step_row_t;

    // DUT connections
    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    nlt_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    nlt_out_t              m_data;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Answer travelling with a directed transaction, picked up on acceptance
    logic     cmd_typed;
    nlt_out_t cmd_golden;

    // Sender asks the sink for one long stall; the sink owns the served flag
    logic hold_req;
    bit   hold_served;
    bit   sender_steady;

    // Behavioural copy of the table
    logic [ID_W-1:0]         node_ids      [MAX_ENTRIES_DEF];
    bit                      node_online   [MAX_ENTRIES_DEF];
    logic [TIME_W-1:0]       node_stamp    [MAX_ENTRIES_DEF];
    logic [BAND_W-1:0]       node_lo       [MAX_ENTRIES_DEF];
    logic [BAND_W-1:0]       node_hi       [MAX_ENTRIES_DEF];
    bit                      node_exceeded [MAX_ENTRIES_DEF];
    logic [NODE_TOTAL_W-1:0] node_count;
    logic [TIME_W-1:0]       cur_timeout;
    logic [BAND_W-1:0]       cur_def_lo;
    logic [BAND_W-1:0]       cur_def_hi;

    nlt_out_t results_due [$];

    // Run statistics
    int error_count;
    int results_checked;
    int sweep_hits;
    int full_replies;
    int missing_replies;
    int bad_band_replies;
    int config_loads;
    int cycle_count;

    node_liveness_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 2-unit clock, rising edge at odd times
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Lowest matching slot among those in use, or -1
    function automatic int lookup_node(input logic [ID_W-1:0] id);
        for (int i = 0; i < int'(node_count); i++) begin
            if (node_ids[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Lookup, appending a fresh offline entry on a miss while there is room
    function automatic int admit_node(input logic [ID_W-1:0] id);
        int slot;
        slot = lookup_node(id);
        if (slot < 0 && int'(node_count) < MAX_ENTRIES_DEF) begin
            slot                = int'(node_count);
            node_ids[slot]      = id;
            node_online[slot]   = 1'b0;
            node_stamp[slot]    = '0;
            node_lo[slot]       = cur_def_lo;
            node_hi[slot]       = cur_def_hi;
            node_exceeded[slot] = 1'b0;
            node_count          = node_count + 1'b1;
        end
        return slot;
    endfunction

    // Applies one command to the copy and returns the result it must give
    function automatic nlt_out_t update_table(input nlt_in_t c);
        nlt_out_t              r;
        int                    slot;
        logic [REQ_BAND_W-1:0] lo;
        logic [REQ_BAND_W-1:0] hi;
        logic [TIME_W-1:0]     age;
        r = '0;
        case (c.func)
            FUNC_SEEN: begin
                slot = admit_node(c.node_id);
                if (slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    r.became_online   = !node_online[slot];
                    node_stamp[slot]  = c.now_ms;
                    node_online[slot] = 1'b1;
                end
            end
            FUNC_CHECK: begin
                slot = lookup_node(c.node_id);
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.exceeded = (c.soil < {1'b0, node_lo[slot]})
                              || (c.soil > {1'b0, node_hi[slot]});
                    node_exceeded[slot] = r.exceeded;
                end
            end
            FUNC_SWEEP: begin
                for (int i = 0; i < int'(node_count); i++) begin
                    age = c.now_ms - node_stamp[i];    // modulo 2^32
                    if (node_online[i] && age >= cur_timeout) begin
                        node_online[i]    = 1'b0;
                        r.timeout_mask[i] = 1'b1;
                    end
                end
            end
            FUNC_OFFLINE: begin
                slot = lookup_node(c.node_id);
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    node_online[slot] = 1'b0;
                end
            end
            FUNC_SET_BAND: begin
                slot = admit_node(c.node_id);
                if (slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    lo = (c.band_low  > BAND_LIMIT) ? BAND_LIMIT : c.band_low;
                    hi = (c.band_high > BAND_LIMIT) ? BAND_LIMIT : c.band_high;
                    // rejected band still leaves a newly made entry behind
                    if (lo >= hi) begin
                        r.status = ST_BAD_BAND;
                    end else begin
                        node_lo[slot] = lo[BAND_W-1:0];
                        node_hi[slot] = hi[BAND_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        r.node_total = node_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Helpers for building stimulus
    // ------------------------------------------------------------------

    function automatic nlt_in_t cmd_of(input logic [FUNC_W-1:0] func,
                                       input logic [ID_W-1:0] id,
                                       input logic [SOIL_W-1:0] soil,
                                       input logic [TIME_W-1:0] now,
                                       input logic [REQ_BAND_W-1:0] lo,
                                       input logic [REQ_BAND_W-1:0] hi);
        nlt_in_t c;
        c.func      = func;
        c.node_id   = id;
        c.soil      = soil;
        c.now_ms    = now;
        c.band_low  = lo;
        c.band_high = hi;
        return c;
    endfunction

    function automatic nlt_out_t res_of(input logic [STATUS_W-1:0] status,
                                        input logic exc,
                                        input logic became,
                                        input logic [MASK_W-1:0] mask,
                                        input logic [NODE_TOTAL_W-1:0] total);
        nlt_out_t r;
        r.status        = status;
        r.exceeded      = exc;
        r.became_online = became;
        r.timeout_mask  = mask;
        r.node_total    = total;
        return r;
    endfunction

    // Idle stretch length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("[%0d] result %0d: %s got %0h, expected %0h",
                 cycle_count, results_checked, what, got, want);
    endtask

    task automatic compare_result(input nlt_out_t got, input nlt_out_t want);
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.exceeded !== want.exceeded)
            report_mismatch("exceeded", 32'(got.exceeded), 32'(want.exceeded));
        if (got.became_online !== want.became_online)
            report_mismatch("became_online", 32'(got.became_online),
                            32'(want.became_online));
        if (got.timeout_mask !== want.timeout_mask)
            report_mismatch("timeout_mask", 32'(got.timeout_mask), 32'(want.timeout_mask));
        if (got.node_total !== want.node_total)
            report_mismatch("node_total", 32'(got.node_total), 32'(want.node_total));
    endtask

    // Everything is sampled at the rising edge. Register writes are mirrored
    // into the copy, results are checked before the command accepted on the
    // same edge is queued (its own result must first pass EVAL and COMMIT).
    always @(posedge aclk) begin : monitor
        nlt_out_t want;
        if (!aresetn) begin
            cur_timeout = TIMEOUT_RST;
            cur_def_lo  = DEF_LOW_RST;
            cur_def_hi  = DEF_HIGH_RST;
            node_count  = '0;
            for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
                node_online[i] = 1'b0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_TIMEOUT:  cur_timeout = cfg_wdata;
                    CFG_DEF_LOW:  cur_def_lo  = cfg_wdata[BAND_W-1:0];
                    CFG_DEF_HIGH: cur_def_hi  = cfg_wdata[BAND_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unsolicited result", 32'(m_data), 32'd0);
                end else begin
                    want = results_due.pop_front();
                    compare_result(m_data, want);
                    if (want.timeout_mask != '0)          sweep_hits++;
                    if (want.status == ST_FULL)           full_replies++;
                    if (want.status == ST_NOT_FOUND)      missing_replies++;
                    if (want.status == ST_BAD_BAND)       bad_band_replies++;
                end
                results_checked++;
            end
            if (s_valid && s_ready) begin
                // predictor always runs so its state follows the block
                want = update_table(s_data);
                results_due.push_back(cmd_typed ? cmd_golden : want);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random back-pressure, with one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        int mode_left;
        int hold_count;
        bit eager;
        m_ready     <= 1'b0;
        hold_served = 1'b0;
        stall_left  = 0;
        mode_left   = 0;
        eager       = 1'b0;
        @(posedge aclk);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_served) begin
                // block fills: one result held plus one command in flight,
                // after which s_ready must drop while the sender keeps going
                m_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    @(negedge aclk);
                end
                hold_served = 1'b1;
            end else begin
                // alternate between always-ready stretches and random stalls
                if (mode_left == 0) begin
                    eager     = ($urandom_range(0, 3) == 0);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                if (stall_left == 0 && !eager) begin
                    stall_left = pick_gap();
                end
                m_ready <= (stall_left == 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks; all called at a falling edge and return at one
    // ------------------------------------------------------------------

    // Offer one transaction and hold it until accepted. Valid stays high on
    // return so a back-to-back transaction needs no re-raise.
    task automatic send_cmd(input nlt_in_t c, input logic typed, input nlt_out_t golden);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_data     <= c;
        cmd_typed  <= typed;
        cmd_golden <= golden;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Stop offering and wait for every queued result to come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Writes every register in turn plus the unused index, which must be
    // dropped. Only called with the block idle.
    task automatic load_config(input logic [31:0] tmo, input logic [31:0] low_word,
                               input logic [31:0] high_word);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_TIMEOUT;
        cfg_wdata <= tmo;
        @(negedge aclk);
        cfg_addr  <= CFG_DEF_LOW;
        cfg_wdata <= low_word;
        @(negedge aclk);
        cfg_addr  <= CFG_DEF_HIGH;
        cfg_wdata <= high_word;
        @(negedge aclk);
        cfg_addr  <= CFG_SPARE;
        cfg_wdata <= $urandom();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        config_loads++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        step_row_t         directed_rows [$];
        nlt_in_t           c;
        logic [TIME_W-1:0] wall_ms;
        logic [TIME_W-1:0] step_max;
        logic [31:0]       tmo;
        logic [31:0]       low_word;
        logic [31:0]       high_word;
        int                fresh_pct;
        int                pick;

        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_data        <= '0;
        cmd_typed     <= 1'b0;
        cmd_golden    <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= '0;
        hold_req      <= 1'b0;
        sender_steady = 1'b0;
        error_count      = 0;
        results_checked  = 0;
        sweep_hits       = 0;
        full_replies     = 0;
        missing_replies  = 0;
        bad_band_replies = 0;
        config_loads     = 0;

        // Directed table, reset settings (timeout 30000, band 30..70).
        // Empty table: lookups miss, a sweep finds nothing.
        directed_rows.push_back({cmd_of(FUNC_CHECK, 8'h00, 8'd0, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_NOT_FOUND, 1'b0, 1'b0, 16'h0, 5'd0)});
        directed_rows.push_back({cmd_of(FUNC_OFFLINE, 8'hFF, 8'd0, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_NOT_FOUND, 1'b0, 1'b0, 16'h0, 5'd0)});
        directed_rows.push_back({cmd_of(FUNC_SWEEP, 8'h00, 8'd0, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b0, 16'h0, 5'd0)});
        // first sighting comes online, a repeat does not
        directed_rows.push_back({cmd_of(FUNC_SEEN, 8'h00, 8'd0, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b1, 16'h0, 5'd1)});
        directed_rows.push_back({cmd_of(FUNC_SEEN, 8'h00, 8'd0, 32'd100, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b0, 16'h0, 5'd1)});
        directed_rows.push_back({cmd_of(FUNC_SEEN, 8'hFF, 8'd0, 32'hFFFF_FFFF, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b1, 16'h0, 5'd2)});
        // default band edges
        directed_rows.push_back({cmd_of(FUNC_CHECK, 8'h00, 8'd29, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b1, 1'b0, 16'h0, 5'd2)});
        directed_rows.push_back({cmd_of(FUNC_CHECK, 8'h00, 8'd30, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b0, 16'h0, 5'd2)});
        directed_rows.push_back({cmd_of(FUNC_CHECK, 8'h00, 8'd70, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b0, 16'h0, 5'd2)});
        directed_rows.push_back({cmd_of(FUNC_CHECK, 8'h00, 8'd71, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b1, 1'b0, 16'h0, 5'd2)});
        directed_rows.push_back({cmd_of(FUNC_CHECK, 8'h00, 8'd255, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b1, 1'b0, 16'h0, 5'd2)});
        // both bounds clamp to 100 -> empty band; equal bounds also rejected
        directed_rows.push_back({cmd_of(FUNC_SET_BAND, 8'h00, 8'd0, 32'd0, 8'd255, 8'd255),
                                 TYPED, res_of(ST_BAD_BAND, 1'b0, 1'b0, 16'h0, 5'd2)});
        directed_rows.push_back({cmd_of(FUNC_SET_BAND, 8'h00, 8'd0, 32'd0, 8'd50, 8'd50),
                                 TYPED, res_of(ST_BAD_BAND, 1'b0, 1'b0, 16'h0, 5'd2)});
        // upper bound clamps, band becomes 0..100
        directed_rows.push_back({cmd_of(FUNC_SET_BAND, 8'h00, 8'd0, 32'd0, 8'd0, 8'd255),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b0, 16'h0, 5'd2)});
        directed_rows.push_back({cmd_of(FUNC_CHECK, 8'h00, 8'd100, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b0, 16'h0, 5'd2)});
        directed_rows.push_back({cmd_of(FUNC_CHECK, 8'h00, 8'd101, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b1, 1'b0, 16'h0, 5'd2)});
        directed_rows.push_back({cmd_of(FUNC_CHECK, 8'h00, 8'd0, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b0, 16'h0, 5'd2)});
        // rejected band on an unknown id still creates the entry
        directed_rows.push_back({cmd_of(FUNC_SET_BAND, 8'h5A, 8'd0, 32'd0, 8'd60, 8'd40),
                                 TYPED, res_of(ST_BAD_BAND, 1'b0, 1'b0, 16'h0, 5'd3)});
        directed_rows.push_back({cmd_of(FUNC_CHECK, 8'h5A, 8'd30, 32'd0, 8'd0, 8'd0),
                                 PREDICT, NO_RES});
        // ageing across the 2^32 wrap, then exactly at the timeout
        directed_rows.push_back({cmd_of(FUNC_SWEEP, 8'h00, 8'd0, 32'd30099, 8'd0, 8'd0),
                                 PREDICT, NO_RES});
        directed_rows.push_back({cmd_of(FUNC_SWEEP, 8'h00, 8'd0, 32'd30100, 8'd0, 8'd0),
                                 PREDICT, NO_RES});
        directed_rows.push_back({cmd_of(FUNC_SEEN, 8'hFF, 8'd0, 32'd30100, 8'd0, 8'd0),
                                 PREDICT, NO_RES});
        directed_rows.push_back({cmd_of(FUNC_OFFLINE, 8'hFF, 8'd0, 32'd0, 8'd0, 8'd0),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b0, 16'h0, 5'd3)});
        // spare command codes: nothing happens, only the total is reported
        directed_rows.push_back({cmd_of(FUNC_SPARE_LO, 8'h00, 8'hFF, 32'hFFFF_FFFF,
                                        8'hFF, 8'hFF),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b0, 16'h0, 5'd3)});
        directed_rows.push_back({cmd_of(FUNC_SPARE_HI, 8'h5A, 8'hFF, 32'hFFFF_FFFF,
                                        8'hFF, 8'hFF),
                                 TYPED, res_of(ST_OK, 1'b0, 1'b0, 16'h0, 5'd3)});

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[k]) begin
            send_cmd(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].res);
        end
        drain_results();

        // Random phases. Ids are mostly drawn from nodes already known so the
        // table is exercised in depth; fresh ids arrive slowly so creation
        // runs under several default bands before the table fills for good.
        wall_ms = 32'hFFFF_0000;    // wraps early in the run
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin tmo = 2000;          low_word = 30;  high_word = 70;  fresh_pct = 5; end
                1: begin tmo = 0;             low_word = 0;   high_word = 100; fresh_pct = 3; end
                // defaults above 100 are kept; upper word bits are dropped
                2: begin tmo = 1;             low_word = 32'hFFFF_FFFF;
                         high_word = 32'hFFFF_FF85;                   fresh_pct = 3; end
                3: begin tmo = 32'hFFFF_FFFF; low_word = 100; high_word = 0;   fresh_pct = 3; end
                4: begin tmo = 700;           low_word = 20;  high_word = 80;  fresh_pct = 5; end
                5: begin tmo = TIMEOUT_RST;   low_word = 32'(DEF_LOW_RST);
                         high_word = 32'(DEF_HIGH_RST);               fresh_pct = 8; end
                6: begin tmo = 150;           low_word = $urandom_range(0, 127);
                         high_word = $urandom_range(0, 127);          fresh_pct = 10; end
                default: begin
                    tmo = $urandom_range(1, 100000);
                    low_word = $urandom(); high_word = $urandom();    fresh_pct = 15;
                end
            endcase
            load_config(tmo, low_word, high_word);
            step_max = (tmo > 20000) ? 32'd5000 : (tmo >> 2) + 32'd2;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // phase 4 opens with the long hold-off on m_ while the sender
                // pushes without gaps and runs into a stalled s_ready
                if (phase == 4 && n == 0) begin
                    hold_req <= 1'b1;
                end
                sender_steady = (phase == 2) || (phase == 6) || (phase == 4 && n < 60);

                pick = $urandom_range(0, 99);
                if (pick < 30)      c.func = FUNC_SEEN;
                else if (pick < 50) c.func = FUNC_CHECK;
                else if (pick < 65) c.func = FUNC_SWEEP;
                else if (pick < 75) c.func = FUNC_OFFLINE;
                else if (pick < 95) c.func = FUNC_SET_BAND;
                else                c.func = FUNC_W'($urandom_range(FUNC_SPARE_LO,
                                                                    FUNC_SPARE_HI));

                if (node_count != 0 && $urandom_range(0, 99) >= fresh_pct) begin
                    c.node_id = node_ids[$urandom_range(0, int'(node_count) - 1)];
                end else begin
                    c.node_id = ID_W'($urandom());
                end

                c.soil = ($urandom_range(0, 9) < 7) ? SOIL_W'($urandom_range(0, 110))
                                                    : SOIL_W'($urandom());

                if ($urandom_range(0, 9) < 6) begin
                    c.band_low  = REQ_BAND_W'($urandom_range(0, 60));
                    c.band_high = REQ_BAND_W'($urandom_range(40, 110));
                end else begin
                    c.band_low  = REQ_BAND_W'($urandom());
                    c.band_high = REQ_BAND_W'($urandom());
                end

                // mostly a running clock, occasionally a time out of nowhere
                wall_ms = wall_ms + $urandom_range(0, step_max);
                c.now_ms = ($urandom_range(0, 19) == 0) ? $urandom() : wall_ms;

                send_cmd(c, PREDICT, NO_RES);
            end
            // sender pauses here until every result is back
            drain_results();
        end
        sender_steady = 1'b0;

        $display("checked %0d results over %0d cycles: %0d sweeps timed nodes out",
                 results_checked, cycle_count, sweep_hits);
        $display("%0d full, %0d unknown-node, %0d bad-band replies; %0d settings, %0d nodes",
                 full_replies, missing_replies, bad_band_replies, config_loads, node_count);
        if (error_count == 0 && results_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: a hang anywhere ends the run as a failure
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
